[rtl/msbr_pkg.sv]
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared constants, codes and controller/datapath types of the MSB-first
// bit reader.
// ----------------------------------------------------------------------------
package msbr_pkg;

  localparam int FIFO_DEPTH   = 64;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FILL_W       = $clog2(FIFO_DEPTH + 1);
  localparam int POS_W        = 48;
  localparam int CACHE_BITS   = 64;
  localparam int CNT_W        = 7;
  localparam int REFILL_LIMIT = 56;
  localparam int MAX_READ     = 32;
  localparam int BYTE_BITS    = 8;
  localparam int VALUE_W      = 32;
  localparam int AVAIL_W      = 10;
  localparam int ACTION_W     = 3;
  localparam int COUNT_W      = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH      = 3'd0,
    ACT_READ_U    = 3'd1,
    ACT_READ_S    = 3'd2,
    ACT_SKIP      = 3'd3,
    ACT_ALIGN     = 3'd4,
    ACT_RESET_POS = 3'd5,
    ACT_CLEAR     = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_LOAD,
    ST_MORE
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic need_refill;
    logic can_refill;
  } dp_status_t;

endpackage

[rtl/msbr_in_if.sv]
// ----------------------------------------------------------------------------
// msbr_in_if
// Request channel of the bit reader: action, pushed byte and bit count.
// ----------------------------------------------------------------------------
interface msbr_in_if;
  import msbr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [7:0]          data_byte;
  logic [COUNT_W-1:0]  bit_len;

  modport source (output valid, output action, output data_byte, output bit_len,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input bit_len,
                  output ready);
endinterface

[rtl/msbr_out_if.sv]
// ----------------------------------------------------------------------------
// msbr_out_if
// Result channel of the bit reader: read value, status and stream position.
// ----------------------------------------------------------------------------
interface msbr_out_if;
  import msbr_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               ok;
  logic [AVAIL_W-1:0] available_bits;
  logic [POS_W-1:0]   bit_position;
  logic               byte_aligned;

  modport source (output valid, output value, output ok, output available_bits,
                  output bit_position, output byte_aligned, input ready);
  modport sink   (input valid, input value, input ok, input available_bits,
                  input bit_position, input byte_aligned, output ready);
endinterface

[rtl/msbr_datapath.sv]
// ----------------------------------------------------------------------------
// msbr_datapath
// Byte FIFO memory, 64-bit bit cache, position counter and result register.
// ----------------------------------------------------------------------------
module msbr_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  msbr_pkg::dp_cmd_t              cmd,
  input  logic [msbr_pkg::ACTION_W-1:0]  req_action,
  input  logic [7:0]                     req_data_byte,
  input  logic [msbr_pkg::COUNT_W-1:0]   req_bit_len,
  output msbr_pkg::dp_status_t           status,
  output logic [msbr_pkg::VALUE_W-1:0]   res_value,
  output logic                           res_ok,
  output logic [msbr_pkg::AVAIL_W-1:0]   res_available_bits,
  output logic [msbr_pkg::POS_W-1:0]     res_bit_position,
  output logic                           res_byte_aligned
);
  import msbr_pkg::*;

  localparam int VIDX_W = $clog2(VALUE_W);

  logic [BYTE_BITS-1:0]  byte_mem [FIFO_DEPTH];
  logic [BYTE_BITS-1:0]  rdata_r;

  logic [FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [CACHE_BITS-1:0] cache_r, cache_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;

  logic [ACTION_W-1:0]   act_r;
  logic [7:0]            data_r;
  logic [COUNT_W-1:0]    count_r;

  logic [VALUE_W-1:0]    value_r;
  logic                  ok_r;
  logic [AVAIL_W-1:0]    avail_r;
  logic [POS_W-1:0]      bitpos_r;
  logic                  aligned_r;

  action_t               act;
  logic [2:0]            pad;
  logic                  req_ok;
  logic [CNT_W-1:0]      req_bits;
  logic                  have;
  logic [CNT_W-1:0]      cnt_cons;
  logic [CACHE_BITS-1:0] shifted;
  logic [VALUE_W:0]      rmask_w;
  logic [VALUE_W-1:0]    rmask;
  logic [VALUE_W-1:0]    raw;
  logic [VIDX_W-1:0]     sign_idx;
  logic [VALUE_W-1:0]    signed_val;
  logic [CACHE_BITS:0]   keep_w;
  logic [CACHE_BITS-1:0] keep;
  logic                  mem_we;
  logic [VALUE_W-1:0]    value_v;
  logic                  ok_v;

  assign act = action_t'(act_r);
  // bits to the next byte boundary of the consumed count
  assign pad = 3'd0 - pos_r[2:0];

  always_comb begin
    req_ok   = 1'b0;
    req_bits = '0;
    case (act)
      ACT_READ_U, ACT_READ_S: begin
        req_ok   = (count_r != '0) && (count_r <= COUNT_W'(MAX_READ));
        req_bits = CNT_W'(count_r);
      end
      ACT_SKIP: begin
        req_ok   = (count_r <= COUNT_W'(CACHE_BITS));
        req_bits = CNT_W'(count_r);
      end
      ACT_ALIGN: begin
        req_ok   = (pad != 3'd0);
        req_bits = CNT_W'(pad);
      end
      default: begin
        req_ok   = 1'b0;
        req_bits = '0;
      end
    endcase
  end

  assign have               = (cnt_r >= req_bits);
  assign status.need_refill = req_ok && !have;
  assign status.can_refill  = (cnt_r <= CNT_W'(REFILL_LIMIT)) && (fill_r != '0);

  // extract the oldest bits of the cache, right aligned
  assign cnt_cons   = cnt_r - req_bits;
  assign shifted    = cache_r >> cnt_cons;
  assign rmask_w    = ({{VALUE_W{1'b0}}, 1'b1} << count_r) - 1'b1;
  assign rmask      = rmask_w[VALUE_W-1:0];
  assign raw        = shifted[VALUE_W-1:0] & rmask;
  assign sign_idx   = VIDX_W'(count_r - 1'b1);
  assign signed_val = ((count_r < COUNT_W'(VALUE_W)) && raw[sign_idx]) ? (raw | ~rmask) : raw;
  assign keep_w     = ({{CACHE_BITS{1'b0}}, 1'b1} << cnt_cons) - 1'b1;
  assign keep       = keep_w[CACHE_BITS-1:0];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    cache_nxt  = cache_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    mem_we     = 1'b0;
    value_v    = '0;
    ok_v       = 1'b0;

    if (cmd.fetch) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
    end

    if (cmd.load) begin
      cache_nxt = {cache_r[CACHE_BITS-BYTE_BITS-1:0], rdata_r};
      cnt_nxt   = cnt_r + CNT_W'(BYTE_BITS);
    end

    if (cmd.exec) begin
      case (act)
        ACT_PUSH: begin
          if (fill_r != FILL_W'(FIFO_DEPTH)) begin
            mem_we     = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
            ok_v       = 1'b1;
          end
        end
        ACT_READ_U, ACT_READ_S: begin
          if (count_r == '0) begin
            ok_v = 1'b1;
          end else if (req_ok && have) begin
            value_v   = (act == ACT_READ_S) ? signed_val : raw;
            cnt_nxt   = cnt_cons;
            pos_nxt   = pos_r + POS_W'(req_bits);
            cache_nxt = cache_r & keep;
            ok_v      = 1'b1;
          end
        end
        ACT_SKIP, ACT_ALIGN: begin
          if (act == ACT_ALIGN && pad == 3'd0) begin
            ok_v = 1'b1;
          end else if (req_ok && have) begin
            cnt_nxt   = cnt_cons;
            pos_nxt   = pos_r + POS_W'(req_bits);
            cache_nxt = cache_r & keep;
            ok_v      = 1'b1;
          end
        end
        ACT_RESET_POS: begin
          pos_nxt = '0;
          ok_v    = 1'b1;
        end
        ACT_CLEAR: begin
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          fill_nxt   = '0;
          cache_nxt  = '0;
          cnt_nxt    = '0;
          pos_nxt    = '0;
          ok_v       = 1'b1;
        end
        default: begin
          ok_v = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      cache_r  <= '0;
      cnt_r    <= '0;
      pos_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      cache_r  <= cache_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r   <= req_action;
      data_r  <= req_data_byte;
      count_r <= req_bit_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      value_r   <= value_v;
      ok_r      <= ok_v;
      avail_r   <= AVAIL_W'({fill_nxt, 3'b000}) + AVAIL_W'(cnt_nxt);
      bitpos_r  <= pos_nxt;
      aligned_r <= (pos_nxt[2:0] == 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[wr_ptr_r] <= data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rdata_r <= byte_mem[rd_ptr_r];
    end
  end

  assign res_value          = value_r;
  assign res_ok             = ok_r;
  assign res_available_bits = avail_r;
  assign res_bit_position   = bitpos_r;
  assign res_byte_aligned   = aligned_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FIFO_DEPTH))
    else $error("byte FIFO fill above depth");

  a_cache_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CACHE_BITS))
    else $error("bit cache count above capacity");

  a_fetch_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> (fill_r != '0) && (cnt_r <= CNT_W'(REFILL_LIMIT)))
    else $error("refill fetch from empty FIFO or into full cache");

endmodule

[rtl/msbr_ctrl.sv]
// ----------------------------------------------------------------------------
// msbr_ctrl
// Sequencer of the bit reader: request accept, byte-wise cache refill and
// result hand-off into the output register.
// ----------------------------------------------------------------------------
module msbr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  msbr_pkg::dp_status_t status,
  output msbr_pkg::dp_cmd_t    cmd
);
  import msbr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.need_refill && status.can_refill) begin
          state_nxt = ST_FETCH;
        end else if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_MORE;
      end
      ST_MORE: begin
        // a started refill runs until the cache is full or the FIFO empty
        if (status.can_refill) begin
          state_nxt = ST_FETCH;
        end else if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.exec ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ready))
    else $error("result overwrites one not yet taken");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("accepted request not checked next");

  a_fetch_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |=> (state_r == ST_LOAD))
    else $error("FIFO read data not loaded into cache");

endmodule

[rtl/msb_first_bit_reader.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// MSB-first bit reader: byte FIFO feeding a 64-bit bit cache, with read,
// signed read, skip, align, position reset and clear requests.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+-------------------------------------
//   in_ch    | in  | valid / ready   | action, data_byte, bit_len
//   out_ch   | out | valid / ready   | value, ok, available_bits,
//            |     |                 | bit_position, byte_aligned
//
// One request at a time: a request that needs no refill is accepted, then
// executed, and each byte moved from the FIFO into the cache adds a memory
// read, a cache shift and a loop check; a refill moves at most 8 bytes.
// Synchronous active-low reset empties the FIFO, cache and position.
// A result waits in the output register; the next request is accepted and
// worked on meanwhile and stalls only at its own hand-off.
// ----------------------------------------------------------------------------
module msb_first_bit_reader (
  input  logic              clk,
  input  logic              rst_n,
  msbr_in_if.sink           in_ch,
  msbr_out_if.source        out_ch
);
  import msbr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  msbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  msbr_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .req_action         (in_ch.action),
    .req_data_byte      (in_ch.data_byte),
    .req_bit_len        (in_ch.bit_len),
    .status             (status),
    .res_value          (out_ch.value),
    .res_ok             (out_ch.ok),
    .res_available_bits (out_ch.available_bits),
    .res_bit_position   (out_ch.bit_position),
    .res_byte_aligned   (out_ch.byte_aligned)
  );

endmodule
